// ===== hdl/mbte_pkg.sv =====
// Shared types and constants for the monochrome bitmap transform engine.
// No dependencies; imported by mono_bitmap_transform_engine, mbte_checker and the testbench.
`timescale 1ns / 1ps
package mbte_pkg;

  localparam int DEF_MAX_WIDTH  = 16;
  localparam int DEF_MAX_HEIGHT = 16;

  localparam int SIZE_W    = 5;
  localparam int CFG_IDX_W = 2;
  localparam int ROW_OUT_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  // Result status codes
  localparam logic [1:0] STAT_DONE     = 2'd0;
  localparam logic [1:0] STAT_OUTSIDE  = 2'd1;
  localparam logic [1:0] STAT_MISMATCH = 2'd2;

  typedef enum logic [3:0] {
    OP_READ      = 4'd0,
    OP_WRITE     = 4'd1,
    OP_TOGGLE    = 4'd2,
    OP_MIRROR_LR = 4'd3,
    OP_MIRROR_TB = 4'd4,
    OP_ROTATE    = 4'd5,
    OP_SHIFT_U   = 4'd6,
    OP_SHIFT_D   = 4'd7,
    OP_SHIFT_L   = 4'd8,
    OP_SHIFT_R   = 4'd9,
    OP_INVERT    = 4'd10,
    OP_CLEAR     = 4'd11,
    OP_COPY      = 4'd12,
    OP_SWAP      = 4'd13,
    OP_PASTE     = 4'd14,
    OP_READ_ROW  = 4'd15
  } op_t;

  typedef struct packed {
    op_t        opcode;
    logic [3:0] pixel_x;
    logic [3:0] pixel_y;
    logic       pixel_value;
    logic [1:0] quarter_turns;
  } in_item_t;

  typedef struct packed {
    logic                 pixel_out;
    logic [ROW_OUT_W-1:0] row_out;
    logic [1:0]           status;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PIX,
    S_ROW,
    S_TB_A,
    S_TB_B,
    S_TB_C,
    S_SHV,
    S_ROT_G,
    S_ROT_P,
    S_COPY,
    S_SWAP,
    S_FIN,
    S_OUT
  } state_t;

endpackage

// ===== hdl/mono_bitmap_transform_engine.sv =====
// Top level of the monochrome bitmap transform engine: image, clipboard and row sequencer.
// Depends on mbte_pkg for payload structs, opcodes, status codes and states.
//
// Channel   Dir  Handshake              Payload
// in_       in   in_valid / in_ready    mbte_pkg::in_item_t   one command
// out_      out  out_valid / out_ready  mbte_pkg::out_item_t  one result per command
// cfg_      in   cfg_valid / cfg_ready  cfg_index, cfg_data   size registers
//
// One command at a time; a single row unit reads and writes one image row per cycle.
// Reset (synchronous, rst_n low) empties image and clipboard and sets both sizes to 16.
// in_ready is low from acceptance until the result transfer; out stalls simply hold.
`timescale 1ns / 1ps
module mono_bitmap_transform_engine #(
  parameter int MAX_WIDTH  = mbte_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = mbte_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  mbte_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output mbte_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mbte_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mbte_pkg::SIZE_W-1:0]         cfg_data
);
  import mbte_pkg::*;

  localparam int MW = MAX_WIDTH;
  localparam int MH = MAX_HEIGHT;
  localparam int XW = $clog2(MW);
  localparam int YW = $clog2(MH);
  localparam int CW = YW + 1;
  localparam int SHW = XW + 1;
  localparam int W_CAP = (MW > 31) ? 31 : MW;
  localparam int H_CAP = (MH > 31) ? 31 : MH;

  // Storage
  logic [MW-1:0] img_r  [MH];
  logic [MW-1:0] clip_r [MH];
  logic [MH-1:0] sc_r   [MW];
  logic [SIZE_W-1:0] wreg_r, hreg_r, clip_w_r, clip_h_r;
  logic [SIZE_W-1:0] clip_w_nxt, clip_h_nxt;

  state_t state_r, state_nxt;
  in_item_t cmd_r, cmd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [1:0] turns_r, turns_nxt;
  logic [1:0] status_r, status_nxt;
  logic tb_after_r, tb_after_nxt;
  logic [MW-1:0] a_r, a_nxt, b_r, b_nxt;
  logic out_valid_r, out_valid_nxt;
  out_item_t out_r, out_nxt;

  // Row unit ports
  logic [YW-1:0] rd_idx, wr_idx, crd_idx, cwr_idx;
  logic [XW-1:0] sc_idx;
  logic [MW-1:0] img_rd, clip_rd, wr_data, cwr_data, sc_rd, rev_rd, row_fn;
  logic img_we, clip_we, sc_we;

  // Effective sizes and column mask
  logic [SIZE_W-1:0] w, h;
  logic [MW-1:0] m;
  logic [SHW-1:0] sh;
  logic [CW-1:0] h_c, w_c, half_h;
  logic in_inside, in_py_ok, mismatch, last_row;

  always_comb begin
    if (wreg_r == '0) w = SIZE_W'(1);
    else if (wreg_r > SIZE_W'(W_CAP)) w = SIZE_W'(W_CAP);
    else w = wreg_r;
    if (hreg_r == '0) h = SIZE_W'(1);
    else if (hreg_r > SIZE_W'(H_CAP)) h = SIZE_W'(H_CAP);
    else h = hreg_r;
    sh     = SHW'(MW) - SHW'(w);
    m      = {MW{1'b1}} >> sh;
    h_c    = CW'(h);
    w_c    = CW'(w);
    half_h = h_c >> 1;
    mismatch = (clip_w_r != w) || (clip_h_r != h);
  end

  // Read ports and the row reversal shared by mirror and row output
  assign img_rd  = img_r[rd_idx];
  assign clip_rd = clip_r[crd_idx];
  assign sc_rd   = MW'(sc_r[sc_idx]);

  always_comb begin
    logic [MW-1:0] rv;
    for (int i = 0; i < MW; i++) rv[i] = img_rd[MW-1-i];
    rev_rd = rv >> sh;
  end

  // Per-row operation for row-wise commands
  always_comb begin
    case (cmd_r.opcode)
      OP_SHIFT_L: row_fn = (img_rd & ~m) | ((img_rd >> 1) & (m >> 1));
      OP_SHIFT_R: row_fn = (img_rd & ~m) | ((img_rd << 1) & m);
      OP_INVERT:  row_fn = img_rd ^ m;
      OP_CLEAR:   row_fn = img_rd & ~m;
      default:    row_fn = (img_rd & ~m) | (rev_rd & m);
    endcase
  end

  assign in_py_ok  = {1'b0, in_data.pixel_y} < h;
  assign in_inside = in_py_ok && ({1'b0, in_data.pixel_x} < w);
  assign last_row  = (cnt_r + CW'(1)) >= h_c;

  // Sequencer: next state, row unit controls and result
  always_comb begin
    logic py_ok, pix_ok;
    logic [MW-1:0] cur;
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    cnt_nxt       = cnt_r;
    turns_nxt     = turns_r;
    status_nxt    = status_r;
    tb_after_nxt  = tb_after_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    clip_w_nxt    = clip_w_r;
    clip_h_nxt    = clip_h_r;
    rd_idx   = cnt_r[YW-1:0];
    crd_idx  = cnt_r[YW-1:0];
    sc_idx   = '0;
    img_we   = 1'b0;
    wr_idx   = cnt_r[YW-1:0];
    wr_data  = row_fn;
    clip_we  = 1'b0;
    cwr_idx  = cnt_r[YW-1:0];
    cwr_data = '0;
    sc_we    = 1'b0;
    cur      = '0;
    py_ok  = {1'b0, cmd_r.pixel_y} < h;
    pix_ok = py_ok && ({1'b0, cmd_r.pixel_x} < w);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt      = in_data;
          cnt_nxt      = '0;
          turns_nxt    = in_data.quarter_turns;
          status_nxt   = STAT_DONE;
          tb_after_nxt = 1'b0;
          case (in_data.opcode)
            OP_READ, OP_WRITE, OP_TOGGLE: begin
              if (!in_inside) status_nxt = STAT_OUTSIDE;
              state_nxt = S_PIX;
            end
            OP_READ_ROW: begin
              if (!in_py_ok) status_nxt = STAT_OUTSIDE;
              state_nxt = S_PIX;
            end
            OP_MIRROR_TB: state_nxt = (half_h == '0) ? S_FIN : S_TB_A;
            OP_ROTATE: begin
              if (w != h) begin
                tb_after_nxt = 1'b1;
                state_nxt    = S_ROW;
              end else if (in_data.quarter_turns == 2'd0) begin
                state_nxt = S_FIN;
              end else begin
                state_nxt = S_ROT_G;
              end
            end
            OP_SHIFT_U, OP_SHIFT_D: state_nxt = S_SHV;
            OP_COPY: state_nxt = S_COPY;
            OP_SWAP, OP_PASTE: begin
              if (mismatch) begin
                status_nxt = STAT_MISMATCH;
                state_nxt  = S_FIN;
              end else begin
                state_nxt = S_SWAP;
              end
            end
            default: state_nxt = S_ROW;
          endcase
        end
      end
      // Single pixel read or update
      S_PIX: begin
        rd_idx  = YW'(cmd_r.pixel_y);
        wr_idx  = YW'(cmd_r.pixel_y);
        wr_data = img_rd;
        wr_data[XW'(cmd_r.pixel_x)] = (cmd_r.opcode == OP_WRITE) ? cmd_r.pixel_value
                                      : !img_rd[XW'(cmd_r.pixel_x)];
        img_we    = pix_ok && (cmd_r.opcode == OP_WRITE || cmd_r.opcode == OP_TOGGLE);
        state_nxt = S_FIN;
      end
      // One row per cycle through the row function
      S_ROW: begin
        img_we  = 1'b1;
        cnt_nxt = cnt_r + CW'(1);
        if (last_row) begin
          cnt_nxt   = '0;
          state_nxt = (tb_after_r && half_h != '0) ? S_TB_A : S_FIN;
        end
      end
      // Top-bottom mirror: fetch upper, swap lower, write upper
      S_TB_A: begin
        a_nxt     = img_rd;
        state_nxt = S_TB_B;
      end
      S_TB_B: begin
        rd_idx    = YW'(h_c - CW'(1) - cnt_r);
        wr_idx    = rd_idx;
        wr_data   = (img_rd & ~m) | (a_r & m);
        img_we    = 1'b1;
        b_nxt     = img_rd;
        state_nxt = S_TB_C;
      end
      S_TB_C: begin
        wr_data = (a_r & ~m) | (b_r & m);
        img_we  = 1'b1;
        cnt_nxt = cnt_r + CW'(1);
        state_nxt = ((cnt_r + CW'(1)) >= half_h) ? S_FIN : S_TB_A;
      end
      // Vertical shift: carry the previous row forward one step
      S_SHV: begin
        rd_idx = (cmd_r.opcode == OP_SHIFT_U) ? cnt_r[YW-1:0]
                 : YW'(h_c - CW'(1) - cnt_r);
        cur    = (cnt_r < h_c) ? img_rd : '0;
        wr_idx = (cmd_r.opcode == OP_SHIFT_U) ? YW'(cnt_r - CW'(1))
                 : YW'(h_c - cnt_r);
        wr_data = (b_r & ~m) | (cur & m);
        img_we  = (cnt_r != '0);
        b_nxt   = img_rd;
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == h_c) begin
          cnt_nxt   = '0;
          state_nxt = S_FIN;
        end
      end
      // Rotate: gather columns into scratch, then write them back last column first
      S_ROT_G: begin
        sc_we   = 1'b1;
        cnt_nxt = cnt_r + CW'(1);
        if (last_row) begin
          cnt_nxt   = '0;
          state_nxt = S_ROT_P;
        end
      end
      S_ROT_P: begin
        sc_idx  = XW'(w_c - CW'(1) - cnt_r);
        wr_data = (img_rd & ~m) | (sc_rd & m);
        img_we  = 1'b1;
        cnt_nxt = cnt_r + CW'(1);
        if (last_row) begin
          cnt_nxt   = '0;
          turns_nxt = turns_r - 2'd1;
          state_nxt = (turns_r == 2'd1) ? S_FIN : S_ROT_G;
        end
      end
      // Copy the whole store into the clipboard
      S_COPY: begin
        clip_we  = 1'b1;
        cwr_data = (cnt_r < h_c) ? (img_rd & m) : '0;
        cnt_nxt  = cnt_r + CW'(1);
        if ((cnt_r + CW'(1)) >= CW'(MH)) begin
          cnt_nxt    = '0;
          clip_w_nxt = w;
          clip_h_nxt = h;
          state_nxt  = S_FIN;
        end
      end
      // Swap or paste against the clipboard
      S_SWAP: begin
        wr_data  = (img_rd & ~m) | (clip_rd & m);
        img_we   = 1'b1;
        cwr_data = (clip_rd & ~m) | (img_rd & m);
        clip_we  = (cmd_r.opcode == OP_SWAP);
        cnt_nxt  = cnt_r + CW'(1);
        if (last_row) begin
          cnt_nxt   = '0;
          state_nxt = S_FIN;
        end
      end
      // Form the result from row pixel_y
      S_FIN: begin
        rd_idx            = YW'(cmd_r.pixel_y);
        out_nxt.pixel_out = pix_ok ? img_rd[XW'(cmd_r.pixel_x)] : 1'b0;
        out_nxt.row_out   = py_ok ? ROW_OUT_W'(rev_rd) : '0;
        out_nxt.status    = status_r;
        out_valid_nxt     = 1'b1;
        state_nxt         = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      turns_r     <= '0;
      status_r    <= STAT_DONE;
      tb_after_r  <= 1'b0;
      wreg_r      <= SIZE_W'(16);
      hreg_r      <= SIZE_W'(16);
      clip_w_r    <= '0;
      clip_h_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      turns_r     <= turns_nxt;
      status_r    <= status_nxt;
      tb_after_r  <= tb_after_nxt;
      clip_w_r    <= clip_w_nxt;
      clip_h_r    <= clip_h_nxt;
      if (cfg_valid && cfg_index == REG_IMAGE_WIDTH) wreg_r <= cfg_data;
      if (cfg_valid && cfg_index == REG_IMAGE_HEIGHT) hreg_r <= cfg_data;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    out_r <= out_nxt;
  end

  // Image and clipboard rows: cleared on reset, one write each per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MH; i++) begin
        img_r[i]  <= '0;
        clip_r[i] <= '0;
      end
    end else begin
      if (img_we) img_r[wr_idx] <= wr_data;
      if (clip_we) clip_r[cwr_idx] <= cwr_data;
    end
  end

  // Scratch transpose: row y of the image lands in column y
  always_ff @(posedge clk) begin
    if (sc_we) begin
      for (int x = 0; x < MW; x++) sc_r[x][cnt_r[YW-1:0]] <= img_rd[x];
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  // Checks
  a_busy_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_FIN)) else $error("result without finish step");
  a_mismatch_op: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == STAT_MISMATCH |->
      cmd_r.opcode == OP_SWAP || cmd_r.opcode == OP_PASTE)
    else $error("mismatch status on non-clipboard command");
  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ({1'b0, cmd_r.pixel_x} >= w || {1'b0, cmd_r.pixel_y} >= h) |->
      out_data.pixel_out == 1'b0) else $error("pixel outside image not zero");

endmodule

// ===== tb/mbte_checker.sv =====
// Result checker for the monochrome bitmap transform engine: watches the command,
// result and size-register channels, keeps its own image and clipboard, compares.
// Depends on mbte_pkg for payload structs, opcodes, status codes and register indexes.
`timescale 1ns / 1ps
module mbte_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  mbte_pkg::in_item_t   in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  mbte_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [4:0]           cfg_data,
  output int                   fail_count,
  output int                   results_pending
);
  import mbte_pkg::*;

  logic [15:0] img [16];
  logic [15:0] clip [16];
  logic [4:0]  reg_w, reg_h;
  logic [4:0]  clip_w, clip_h;
  out_item_t   expected_results [$];

  // Count and print one mismatch
  task automatic report(input string what, input int got, input int want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic int clamp16(input logic [4:0] v);
    if (v == 0) return 1;
    if (v > 16) return 16;
    return v;
  endfunction

  // Mirror every used row left-right
  task automatic flip_lr(input int w, input int h);
    logic [15:0] r;
    for (int y = 0; y < h; y++) begin
      r = img[y];
      for (int x = 0; x < w; x++) r[x] = img[y][w-1-x];
      img[y] = r;
    end
  endtask

  task automatic flip_tb(input int h, input logic [15:0] m);
    logic [15:0] a, b;
    for (int y = 0; y < h / 2; y++) begin
      a = img[y];
      b = img[h-1-y];
      img[y]     = (a & ~m) | (b & m);
      img[h-1-y] = (b & ~m) | (a & m);
    end
  endtask

  // Apply one command and queue the result it should give
  task automatic apply_command(input in_item_t c);
    int w, h;
    logic [15:0] m, a, row;
    logic [15:0] snap [16];
    logic pix_ok;
    out_item_t r;
    w = clamp16(reg_w);
    h = clamp16(reg_h);
    m = 16'((32'd1 << w) - 1);
    pix_ok = (c.pixel_x < w) && (c.pixel_y < h);
    r = '0;
    r.status = STAT_DONE;
    case (c.opcode)
      OP_READ:   if (!pix_ok) r.status = STAT_OUTSIDE;
      OP_WRITE:  if (pix_ok) img[c.pixel_y][c.pixel_x] = c.pixel_value;
                 else r.status = STAT_OUTSIDE;
      OP_TOGGLE: if (pix_ok) img[c.pixel_y][c.pixel_x] = ~img[c.pixel_y][c.pixel_x];
                 else r.status = STAT_OUTSIDE;
      OP_MIRROR_LR: flip_lr(w, h);
      OP_MIRROR_TB: flip_tb(h, m);
      OP_ROTATE: begin
        if (w != h) begin
          flip_lr(w, h);
          flip_tb(h, m);
        end else begin
          for (int k = 0; k < c.quarter_turns; k++) begin
            snap = img;
            for (int y = 0; y < w; y++)
              for (int x = 0; x < w; x++) img[y][x] = snap[x][w-1-y];
          end
        end
      end
      OP_SHIFT_U: begin
        for (int y = 0; y + 1 < h; y++) img[y] = (img[y] & ~m) | (img[y+1] & m);
        img[h-1] &= ~m;
      end
      OP_SHIFT_D: begin
        for (int y = h - 1; y > 0; y--) img[y] = (img[y] & ~m) | (img[y-1] & m);
        img[0] &= ~m;
      end
      OP_SHIFT_L:
        for (int y = 0; y < h; y++) img[y] = (img[y] & ~m) | ((img[y] >> 1) & (m >> 1));
      OP_SHIFT_R:
        for (int y = 0; y < h; y++) img[y] = (img[y] & ~m) | ((img[y] << 1) & m);
      OP_INVERT: for (int y = 0; y < h; y++) img[y] ^= m;
      OP_CLEAR:  for (int y = 0; y < h; y++) img[y] &= ~m;
      OP_COPY: begin
        for (int y = 0; y < 16; y++) clip[y] = (y < h) ? (img[y] & m) : 16'h0;
        clip_w = 5'(w);
        clip_h = 5'(h);
      end
      OP_SWAP, OP_PASTE: begin
        if (clip_w != w || clip_h != h) r.status = STAT_MISMATCH;
        else begin
          for (int y = 0; y < h; y++) begin
            a = img[y];
            img[y] = (a & ~m) | (clip[y] & m);
            if (c.opcode == OP_SWAP) clip[y] = (clip[y] & ~m) | (a & m);
          end
        end
      end
      default: if (c.pixel_y >= h) r.status = STAT_OUTSIDE;
    endcase
    // Row out: column 0 lands on the most significant used bit
    row = '0;
    if (c.pixel_y < h)
      for (int x = 0; x < w; x++) row[w-1-x] = img[c.pixel_y][x];
    r.row_out = row;
    r.pixel_out = pix_ok ? img[c.pixel_y][c.pixel_x] : 1'b0;
    expected_results.push_back(r);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        img[i] = '0;
        clip[i] = '0;
      end
      reg_w = 5'd16;
      reg_h = 5'd16;
      clip_w = '0;
      clip_h = '0;
      expected_results.delete();
      fail_count = 0;
    end else begin
      // Register writes first, then a command, then the result transfer
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_IMAGE_WIDTH) reg_w = cfg_data;
        else if (cfg_index == REG_IMAGE_HEIGHT) reg_h = cfg_data;
      end
      if (in_valid && in_ready) apply_command(in_data);
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) report("unexpected result", 0, 0);
        else begin
          want = expected_results.pop_front();
          if (out_data.pixel_out !== want.pixel_out)
            report("pixel_out", out_data.pixel_out, want.pixel_out);
          if (out_data.row_out !== want.row_out)
            report("row_out", out_data.row_out, want.row_out);
          if (out_data.status !== want.status)
            report("status", out_data.status, want.status);
        end
      end
    end
    results_pending = expected_results.size();
  end
endmodule

// ===== tb/mono_bitmap_transform_engine_test.sv =====
// Testbench top for the monochrome bitmap transform engine: drives commands and
// size writes with bursty sender and stalling receiver, gives the verdict.
// Depends on mbte_pkg, mono_bitmap_transform_engine and mbte_checker.
`timescale 1ns / 1ps
module mono_bitmap_transform_engine_test;
  import mbte_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_ready;
  in_item_t in_data = '0;
  logic out_valid, out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [4:0] cfg_data = '0;
  int fail_count, results_pending;
  int cycle_count = 0;
  bit long_hold = 1'b0;
  logic [4:0] cur_w = 5'd16, cur_h = 5'd16;

  mono_bitmap_transform_engine dut (.*);
  mbte_checker checker_i (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Give up well past the slowest correct run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 400000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, quiet stretches, and the long hold-off when asked
  initial begin
    int mode;
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(5, 40)) begin
        @(negedge clk);
        if (long_hold) out_ready <= 1'b0;
        else if (mode == 0) out_ready <= 1'b1;
        else out_ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // Offer one command on a fresh falling edge and wait for its transfer
  task automatic send_command(input op_t op, input int x, input int y,
                              input bit v, input int qt);
    in_item_t c;
    c.opcode = op;
    c.pixel_x = 4'(x);
    c.pixel_y = 4'(y);
    c.pixel_value = v;
    c.quarter_turns = 2'(qt);
    @(negedge clk);
    in_data <= c;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Drain, settle, then write one size register
  task automatic write_size(input logic [1:0] idx, input logic [4:0] val);
    while (results_pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) cur_w = val; else cur_h = val;
  endtask

  task automatic random_command();
    int w, h, x, y;
    op_t op;
    w = (cur_w == 0) ? 1 : (cur_w > 16 ? 16 : cur_w);
    h = (cur_h == 0) ? 1 : (cur_h > 16 ? 16 : cur_h);
    op = op_t'($urandom_range(0, 15));
    // Pixel commands dominate so the image fills with content
    if ($urandom_range(0, 2) == 0) op = op_t'($urandom_range(0, 2));
    x = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(0, w - 1);
    y = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(0, h - 1);
    send_command(op, x, y, $urandom_range(0, 1), $urandom_range(0, 3));
  endtask

  task automatic random_phase(input int n);
    int left;
    left = n;
    while (left > 0) begin
      repeat ($urandom_range(1, 8)) begin
        if (left > 0) begin
          random_command();
          left--;
        end
      end
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end
  endtask

  initial begin
    int settings [6][2] = '{'{16, 16}, '{1, 1}, '{5, 5}, '{16, 7}, '{0, 31}, '{9, 9}};
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: corners, every command, empty clipboard
    send_command(OP_SWAP, 0, 0, 0, 0);
    send_command(OP_PASTE, 0, 0, 0, 0);
    send_command(OP_WRITE, 0, 0, 1, 0);
    send_command(OP_WRITE, 15, 15, 1, 0);
    send_command(OP_TOGGLE, 15, 0, 0, 0);
    send_command(OP_READ, 15, 15, 0, 0);
    send_command(OP_COPY, 0, 0, 0, 0);
    send_command(OP_MIRROR_LR, 0, 0, 0, 0);
    send_command(OP_MIRROR_TB, 0, 15, 0, 0);
    send_command(OP_ROTATE, 0, 0, 0, 1);
    send_command(OP_ROTATE, 0, 0, 0, 3);
    send_command(OP_ROTATE, 0, 0, 0, 0);
    send_command(OP_SHIFT_U, 0, 0, 0, 0);
    send_command(OP_SHIFT_D, 0, 0, 0, 0);
    send_command(OP_SHIFT_L, 0, 0, 0, 0);
    send_command(OP_SHIFT_R, 0, 0, 0, 0);
    send_command(OP_INVERT, 0, 3, 0, 0);
    send_command(OP_SWAP, 3, 3, 0, 0);
    send_command(OP_PASTE, 3, 3, 0, 0);
    send_command(OP_READ_ROW, 0, 15, 0, 0);
    send_command(OP_CLEAR, 0, 0, 0, 0);

    // Fill the block while the receiver holds off, then release it
    long_hold = 1'b1;
    fork
      begin
        repeat (300) @(negedge clk);
        long_hold = 1'b0;
      end
      random_phase(6);
    join

    // Random phases under several sizes, extremes included
    foreach (settings[i]) begin
      write_size(REG_IMAGE_WIDTH, 5'(settings[i][0]));
      write_size(REG_IMAGE_HEIGHT, 5'(settings[i][1]));
      send_command(OP_WRITE, 16, 0, 1, 0);
      send_command(OP_ROTATE, 0, 0, 0, 2);
      send_command(OP_READ_ROW, 0, 15, 0, 0);
      random_phase(62);
    end

    while (results_pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

// ===== sim.f =====
hdl/mbte_pkg.sv
hdl/mono_bitmap_transform_engine.sv
tb/mbte_checker.sv
tb/mono_bitmap_transform_engine_test.sv
